// ===== hdl/acc_alu_pkg.sv =====
// types and constants shared by the accumulator alu block
// no dependencies; compiled first

package acc_alu_pkg;

  // operation codes carried on req_type
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_ADC  = 4'd1,
    OP_SUB  = 4'd2,
    OP_SBC  = 4'd3,
    OP_AND  = 4'd4,
    OP_XOR  = 4'd5,
    OP_OR   = 4'd6,
    OP_CP   = 4'd7,
    OP_INC  = 4'd8,
    OP_DEC  = 4'd9,
    OP_RLCA = 4'd10,
    OP_RLA  = 4'd11,
    OP_RRCA = 4'd12,
    OP_RRA  = 4'd13,
    OP_LOAD = 4'd14
  } alu_op_t;

  // flag register layout
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } alu_flags_t;

  localparam logic [3:0] NIBBLE_MAX = 4'hf;
  localparam logic [3:0] NIBBLE_MIN = 4'h0;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;

endpackage

// ===== hdl/acc_alu_in_if.sv =====
// input and result channel interfaces for the accumulator alu
// no package dependency; compiled after acc_alu_pkg

interface acc_alu_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] req_type;
  logic [7:0] operand;

  modport source (output valid, output req_type, output operand, input ready);
  modport sink   (input valid, input req_type, input operand, output ready);
endinterface

interface acc_alu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] acc_out;
  logic [7:0] result_byte;
  logic       zero_out;
  logic       subtract_out;
  logic       half_carry_out;
  logic       carry_out;

  modport source (
    output valid, output acc_out, output result_byte, output zero_out,
    output subtract_out, output half_carry_out, output carry_out, input ready
  );
  modport sink (
    input valid, input acc_out, input result_byte, input zero_out,
    input subtract_out, input half_carry_out, input carry_out, output ready
  );
endinterface

// ===== hdl/accumulator_alu_with_flags.sv =====
// 8-bit accumulator alu with z, n, h and c flags: input register, one step of
// alu logic, result register. an accepted item's result is registered in the result register.
// throughput one item per cycle; stalls only when the result register is held.
// the accumulator and flags feed back through the single alu step, updated as each item fires.
// synchronous active-low reset clears the accumulator, flags and both valids.
// depends on acc_alu_pkg and acc_alu_in_if.sv

module accumulator_alu_with_flags
  import acc_alu_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  acc_alu_in_if.sink     in_ch,
  acc_alu_out_if.source  out_ch
);

  // input register
  logic       s1_v_r;
  alu_op_t    s1_op_r;
  logic [7:0] s1_b_r;

  // architectural state
  logic [7:0] acc_r,   acc_nxt;
  alu_flags_t flags_r, flags_nxt;

  // result register
  logic       out_v_r;
  logic [7:0] out_acc_r;
  logic [7:0] out_res_r, res_nxt;
  alu_flags_t out_flags_r;

  logic fire;
  logic out_free;

  assign out_free    = !out_v_r || out_ch.ready;
  assign fire        = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;

  // input stage capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r <= alu_op_t'(in_ch.req_type);
      s1_b_r  <= in_ch.operand;
    end
  end

  // alu datapath
  logic       cin;
  logic       c_use;
  logic [8:0] sum9;
  logic [4:0] hsum5;
  logic [8:0] diff9;
  logic [4:0] hdiff5;
  logic [7:0] inc_v;
  logic [7:0] dec_v;
  logic [7:0] logic_v;

  assign cin    = flags_r.c;
  assign c_use  = cin && (s1_op_r == OP_ADC || s1_op_r == OP_SBC);
  assign sum9   = {1'b0, acc_r} + {1'b0, s1_b_r} + {8'd0, c_use};
  assign hsum5  = {1'b0, acc_r[3:0]} + {1'b0, s1_b_r[3:0]} + {4'd0, c_use};
  assign diff9  = {1'b0, acc_r} - {1'b0, s1_b_r} - {8'd0, c_use};
  assign hdiff5 = {1'b0, acc_r[3:0]} - {1'b0, s1_b_r[3:0]} - {4'd0, c_use};
  assign inc_v  = s1_b_r + 8'd1;
  assign dec_v  = s1_b_r - 8'd1;

  always_comb begin
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    res_nxt   = acc_r;
    logic_v   = acc_r & s1_b_r;
    unique case (s1_op_r)
      OP_ADD, OP_ADC: begin
        acc_nxt   = sum9[7:0];
        flags_nxt = '{z: sum9[7:0] == BYTE_ZERO, n: 1'b0, h: hsum5[4], c: sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        if (s1_op_r != OP_CP) begin
          acc_nxt = diff9[7:0];
        end
        flags_nxt = '{z: diff9[7:0] == BYTE_ZERO, n: 1'b1, h: hdiff5[4], c: diff9[8]};
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (s1_op_r == OP_XOR) begin
          logic_v = acc_r ^ s1_b_r;
        end else if (s1_op_r == OP_OR) begin
          logic_v = acc_r | s1_b_r;
        end
        acc_nxt   = logic_v;
        flags_nxt = '{z: logic_v == BYTE_ZERO, n: 1'b0, h: s1_op_r == OP_AND, c: 1'b0};
      end
      OP_INC: begin
        flags_nxt = '{z: inc_v == BYTE_ZERO, n: 1'b0,
                      h: s1_b_r[3:0] == NIBBLE_MAX, c: cin};
      end
      OP_DEC: begin
        flags_nxt = '{z: dec_v == BYTE_ZERO, n: 1'b1,
                      h: s1_b_r[3:0] == NIBBLE_MIN, c: cin};
      end
      OP_RLCA: begin
        acc_nxt   = {acc_r[6:0], acc_r[7]};
        flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_r[7]};
      end
      OP_RLA: begin
        acc_nxt   = {acc_r[6:0], cin};
        flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_r[7]};
      end
      OP_RRCA: begin
        acc_nxt   = {acc_r[0], acc_r[7:1]};
        flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_r[0]};
      end
      OP_RRA: begin
        acc_nxt   = {cin, acc_r[7:1]};
        flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_r[0]};
      end
      OP_LOAD: begin
        acc_nxt = s1_b_r;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase

    // written-back byte
    if (s1_op_r == OP_INC) begin
      res_nxt = inc_v;
    end else if (s1_op_r == OP_DEC) begin
      res_nxt = dec_v;
    end else begin
      res_nxt = acc_nxt;
    end
  end

  // state update, tied to the result register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 8'd0;
      flags_r <= '0;
    end else if (fire) begin
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_acc_r   <= acc_nxt;
      out_res_r   <= res_nxt;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.acc_out        = out_acc_r;
  assign out_ch.result_byte    = out_res_r;
  assign out_ch.zero_out       = out_flags_r.z;
  assign out_ch.subtract_out   = out_flags_r.n;
  assign out_ch.half_carry_out = out_flags_r.h;
  assign out_ch.carry_out      = out_flags_r.c;

  // checks
  a_acc_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_acc_r == acc_r && out_flags_r == flags_r))
    else $error("held result disagrees with accumulator state");

  a_in_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && out_v_r))
    else $error("input stalled with room in the pipe");

  a_rotate_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (s1_op_r == OP_RLCA || s1_op_r == OP_RLA ||
              s1_op_r == OP_RRCA || s1_op_r == OP_RRA))
    |=> (!out_flags_r.z && !out_flags_r.n && !out_flags_r.h))
    else $error("rotate left z, n or h set");

  a_incdec_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (s1_op_r == OP_INC || s1_op_r == OP_DEC)) |=> $stable(acc_r))
    else $error("inc or dec changed the accumulator");

endmodule
